// ----- design/lcs_pkg.sv -----
// Shared constants, register and code names, and the chain control type for the
// convolution block. No dependencies.
package lcs_pkg;

    localparam int MAX_TAPS_DEF     = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int RES_W      = 40;
    localparam int KL_W       = 6;
    localparam int SHAPE_W    = 2;
    localparam int TAP_W      = 5;
    localparam int IDX_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE  = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_FULL  = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SAME  = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_VALID = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Commands from the sequencer to every cell of the delay line.
    typedef struct packed {
        logic shift;
        logic zero;
        logic clear;
    } t_chain_ctl;

endpackage

// ----- design/lcs_req_if.sv -----
// Request channel of the convolution block: samples and kernel coefficient loads.
// Depends on lcs_pkg.
interface lcs_req_if #(
    parameter int SAMPLE_WIDTH = lcs_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [lcs_pkg::TAP_W-1:0]         tap_index;
    logic signed [SAMPLE_WIDTH-1:0]    value_re;
    logic signed [SAMPLE_WIDTH-1:0]    value_im;
    logic                              last_sample;

    modport source (
        output valid, operation, tap_index, value_re, value_im, last_sample,
        input  ready
    );
    modport sink (
        input  valid, operation, tap_index, value_re, value_im, last_sample,
        output ready
    );
endinterface

// ----- design/lcs_res_if.sv -----
// Result channel of the convolution block: convolution outputs for samples and tail steps.
// Depends on lcs_pkg.
interface lcs_res_if ();
    logic                               valid;
    logic                               ready;
    logic signed [lcs_pkg::RES_W-1:0]   result_re;
    logic signed [lcs_pkg::RES_W-1:0]   result_im;
    logic                               final_result;

    modport source (
        output valid, result_re, result_im, final_result,
        input  ready
    );
    modport sink (
        input  valid, result_re, result_im, final_result,
        output ready
    );
endinterface

// ----- design/lcs_cell.sv -----
// One tap of the convolution chain: kernel tap, delay-line entry, complex product
// and one partial-sum adder. Depends on lcs_pkg.
module lcs_cell #(
    parameter int SAMPLE_WIDTH = lcs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lcs_pkg::t_chain_ctl                i_ctl,
    input  logic                               i_cplx,
    input  logic                               i_on,
    input  logic                               i_load,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_load_re,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_load_im,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_x_re,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_x_im,
    input  logic                               i_tok,
    input  logic signed [lcs_pkg::RES_W-1:0]   i_psum_re,
    input  logic signed [lcs_pkg::RES_W-1:0]   i_psum_im,
    output logic signed [SAMPLE_WIDTH-1:0]     o_x_re,
    output logic signed [SAMPLE_WIDTH-1:0]     o_x_im,
    output logic                               o_tok,
    output logic signed [lcs_pkg::RES_W-1:0]   o_psum_re,
    output logic signed [lcs_pkg::RES_W-1:0]   o_psum_im
);
    localparam int PW = 2 * SAMPLE_WIDTH;
    localparam int CW = PW + 1;

    logic signed [SAMPLE_WIDTH-1:0]   r_h_re, r_h_im, r_x_re, r_x_im;
    logic signed [SAMPLE_WIDTH-1:0]   w_hr, w_hi, w_xi;
    logic signed [PW-1:0]             r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [CW-1:0]             r_c_re, r_c_im;
    logic signed [lcs_pkg::RES_W-1:0] w_c_re, w_c_im;
    logic signed [lcs_pkg::RES_W-1:0] r_psum_re, r_psum_im;
    logic                             r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_re <= '0;
            r_h_im <= '0;
            r_x_re <= '0;
            r_x_im <= '0;
            r_tok  <= 1'b0;
        end else begin
            if (i_load) begin
                r_h_re <= i_load_re;
                r_h_im <= i_load_im;
            end
            if (i_ctl.clear) begin
                r_x_re <= '0;
                r_x_im <= '0;
            end else if (i_ctl.shift) begin
                r_x_re <= i_x_re;
                r_x_im <= i_x_im;
            end
            r_tok <= i_tok;
        end
    end

    // Taps beyond the kernel length contribute nothing; real mode drops the
    // imaginary parts.
    assign w_hr = i_on ? r_h_re : '0;
    assign w_hi = (i_on && i_cplx) ? r_h_im : '0;
    assign w_xi = i_cplx ? r_x_im : '0;

    // The delay line holds still while a sum runs, so these stages settle freely.
    always_ff @(posedge i_clk) begin
        r_p_rr <= PW'(w_hr) * PW'(r_x_re);
        r_p_ii <= PW'(w_hi) * PW'(w_xi);
        r_p_ri <= PW'(w_hr) * PW'(w_xi);
        r_p_ir <= PW'(w_hi) * PW'(r_x_re);
        r_c_re <= CW'(r_p_rr) - CW'(r_p_ii);
        r_c_im <= CW'(r_p_ri) + CW'(r_p_ir);
    end

    generate
        if (CW >= lcs_pkg::RES_W) begin : g_trunc
            assign w_c_re = r_c_re[lcs_pkg::RES_W-1:0];
            assign w_c_im = r_c_im[lcs_pkg::RES_W-1:0];
        end else begin : g_ext
            assign w_c_re = {{(lcs_pkg::RES_W-CW){r_c_re[CW-1]}}, r_c_re};
            assign w_c_im = {{(lcs_pkg::RES_W-CW){r_c_im[CW-1]}}, r_c_im};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_psum_re <= i_psum_re + w_c_re;
            r_psum_im <= i_psum_im + w_c_im;
        end
    end

    assign o_x_re    = r_x_re;
    assign o_x_im    = r_x_im;
    assign o_tok     = r_tok;
    assign o_psum_re = r_psum_re;
    assign o_psum_im = r_psum_im;

endmodule

// ----- design/lcs_ctrl.sv -----
// Sequencer of the convolution block: sample index, shape window, tail flush and
// the hand-off of finished sums to the result register. Depends on lcs_pkg.
module lcs_ctrl #(
    parameter int MAX_TAPS = lcs_pkg::MAX_TAPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_op,
    input  logic                           i_req_last,
    input  logic [lcs_pkg::KL_W-1:0]       i_kl,
    input  logic [lcs_pkg::SHAPE_W-1:0]    i_shape,
    input  logic                           i_done,
    input  logic                           i_slot_free,
    output logic                           o_req_ready,
    output logic [lcs_pkg::KL_W-1:0]       o_len,
    output lcs_pkg::t_chain_ctl            o_ctl,
    output logic                           o_go,
    output logic                           o_push,
    output logic                           o_final
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;
    localparam logic [2:0] S_NEXT = 3'd4;

    // Two register stages in each cell (products, then their combination).
    localparam logic [1:0] PREP_CYC = 2'd2;

    logic [2:0]                  r_state, n_state;
    logic [1:0]                  r_cnt, n_cnt;
    logic [lcs_pkg::IDX_W-1:0]   r_idx, n_idx, r_pos, n_pos, w_pos_inc, w_idx_inc;
    logic [lcs_pkg::KL_W-1:0]    r_left, n_left;
    logic                        r_last, n_last;
    logic [lcs_pkg::KL_W-1:0]    w_len, w_start, w_tail;

    always_comb begin
        if (i_kl == '0) begin
            w_len = lcs_pkg::KL_W'(1);
        end else if (int'(i_kl) > MAX_TAPS) begin
            w_len = lcs_pkg::KL_W'(MAX_TAPS);
        end else begin
            w_len = i_kl;
        end
    end

    always_comb begin
        case (i_shape)
            lcs_pkg::SHAPE_FULL: begin
                w_start = '0;
                w_tail  = w_len - lcs_pkg::KL_W'(1);
            end
            lcs_pkg::SHAPE_SAME: begin
                w_start = w_len >> 1;
                w_tail  = w_len >> 1;
            end
            default: begin
                w_start = w_len - lcs_pkg::KL_W'(1);
                w_tail  = '0;
            end
        endcase
    end

    assign w_idx_inc = (r_idx == '1) ? r_idx : r_idx + lcs_pkg::IDX_W'(1);
    assign w_pos_inc = (r_pos == '1) ? r_pos : r_pos + lcs_pkg::IDX_W'(1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_left  = r_left;
        n_last  = r_last;
        o_ctl   = '0;
        o_go    = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && i_req_op == lcs_pkg::OP_SAMPLE) begin
                    o_ctl.shift = 1'b1;
                    n_pos  = r_idx;
                    n_idx  = w_idx_inc;
                    n_left = i_req_last ? w_tail : '0;
                    n_last = i_req_last;
                    if (r_idx >= lcs_pkg::IDX_W'(w_start)) begin
                        n_state = S_PREP;
                        n_cnt   = PREP_CYC;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_PREP: begin
                if (r_cnt == '0) begin
                    o_go    = 1'b1;
                    n_state = S_RUN;
                end else begin
                    n_cnt = r_cnt - 2'd1;
                end
            end
            S_RUN: begin
                if (i_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_left != '0) begin
                    // Tail flush: shift in a zero and test the window again.
                    o_ctl.shift = 1'b1;
                    o_ctl.zero  = 1'b1;
                    n_left = r_left - lcs_pkg::KL_W'(1);
                    n_pos  = w_pos_inc;
                    if (w_pos_inc >= lcs_pkg::IDX_W'(w_start)) begin
                        n_state = S_PREP;
                        n_cnt   = PREP_CYC;
                    end
                end else begin
                    if (r_last) begin
                        o_ctl.clear = 1'b1;
                        n_idx  = '0;
                        n_last = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_pos   <= '0;
            r_left  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_last  <= n_last;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_len       = w_len;
    // The emission at the end of the tail is the last one of a vector.
    assign o_final     = r_last && (r_left == '0);

endmodule

// ----- design/linear_convolution_shapes.sv -----
// Top level of the convolution block: configuration registers, the chain of tap
// cells, the sequencer and the result register. Depends on lcs_pkg, lcs_req_if,
// lcs_res_if, lcs_cell and lcs_ctrl.
//
// Usage: requests on i_req either load a kernel tap (operation 1) or carry one
// sample (operation 0); last_sample closes a vector. Results leave on o_res:
// one full-precision convolution value for each sample inside the window, and
// the flushed tail after the closing sample, final_result on the last one of a
// vector. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while the
// block is idle.
// Sequence: a coefficient load is taken while the block is idle. A sample
// that produces a result shifts the delay line, waits while two product
// stages settle, then starts a partial sum that walks through every cell of
// the chain, one cell per cycle; the finished sum goes to the result register
// once it is free. A sample or a tail step before the window only shifts the
// delay line. Each flushed tail result runs a further sum through the chain.
// Reset clears the kernel, the delay line, the sample index and the registers
// (kernel length 1, full shape, real mode). When the receiver stalls, the
// finished result waits in the output register; the next sum may still be
// computed and is held in the last cell until the register frees up.
module linear_convolution_shapes #(
    parameter int MAX_TAPS     = lcs_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_WIDTH = lcs_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lcs_req_if.sink                              i_req,
    lcs_res_if.source                            o_res,
    input  logic                                 i_cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    logic [lcs_pkg::KL_W-1:0]    r_kl;
    logic [lcs_pkg::SHAPE_W-1:0] r_shape;
    logic                        r_cplx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kl    <= lcs_pkg::KL_W'(1);
            r_shape <= lcs_pkg::SHAPE_FULL;
            r_cplx  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcs_pkg::REG_KERNEL_LENGTH: r_kl    <= i_cfg_data[lcs_pkg::KL_W-1:0];
                lcs_pkg::REG_SHAPE_MODE:    r_shape <= i_cfg_data[lcs_pkg::SHAPE_W-1:0];
                lcs_pkg::REG_COMPLEX_MODE:  r_cplx  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lcs_pkg::t_chain_ctl          w_ctl;
    logic [lcs_pkg::KL_W-1:0]     w_len;
    logic                         w_ready, w_go, w_push, w_final, w_slot_free, w_accept;
    logic                         w_load_op;
    logic [MAX_TAPS:0]            w_tok;
    logic signed [SAMPLE_WIDTH-1:0]     w_x_re  [0:MAX_TAPS-1];
    logic signed [SAMPLE_WIDTH-1:0]     w_x_im  [0:MAX_TAPS-1];
    logic signed [SAMPLE_WIDTH-1:0]     w_in_re, w_in_im;
    logic signed [lcs_pkg::RES_W-1:0]   w_psum_re [0:MAX_TAPS];
    logic signed [lcs_pkg::RES_W-1:0]   w_psum_im [0:MAX_TAPS];

    logic                               r_out_valid;
    logic signed [lcs_pkg::RES_W-1:0]   r_res_re, r_res_im;
    logic                               r_res_final;

    assign w_accept    = i_req.valid && w_ready;
    assign w_load_op   = w_accept && (i_req.operation == lcs_pkg::OP_LOAD);
    assign w_slot_free = !r_out_valid || o_res.ready;

    lcs_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .i_req_last  (i_req.last_sample),
        .i_kl        (r_kl),
        .i_shape     (r_shape),
        .i_done      (w_tok[MAX_TAPS]),
        .i_slot_free (w_slot_free),
        .o_req_ready (w_ready),
        .o_len       (w_len),
        .o_ctl       (w_ctl),
        .o_go        (w_go),
        .o_push      (w_push),
        .o_final     (w_final)
    );

    // Flush shifts feed zeros; real mode stores a zero imaginary part.
    assign w_in_re = w_ctl.zero ? '0 : i_req.value_re;
    assign w_in_im = (w_ctl.zero || !r_cplx) ? '0 : i_req.value_im;

    assign w_tok[0]     = w_go;
    assign w_psum_re[0] = '0;
    assign w_psum_im[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_TAPS; g++) begin : g_cell
            logic                           w_on, w_load;
            logic signed [SAMPLE_WIDTH-1:0] w_xin_re, w_xin_im;

            assign w_on   = (g < int'(w_len));
            assign w_load = w_load_op && (int'(i_req.tap_index) == g);

            if (g == 0) begin : g_head
                assign w_xin_re = w_in_re;
                assign w_xin_im = w_in_im;
            end else begin : g_link
                assign w_xin_re = w_x_re[g-1];
                assign w_xin_im = w_x_im[g-1];
            end

            lcs_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_cplx    (r_cplx),
                .i_on      (w_on),
                .i_load    (w_load),
                .i_load_re (i_req.value_re),
                .i_load_im (i_req.value_im),
                .i_x_re    (w_xin_re),
                .i_x_im    (w_xin_im),
                .i_tok     (w_tok[g]),
                .i_psum_re (w_psum_re[g]),
                .i_psum_im (w_psum_im[g]),
                .o_x_re    (w_x_re[g]),
                .o_x_im    (w_x_im[g]),
                .o_tok     (w_tok[g+1]),
                .o_psum_re (w_psum_re[g+1]),
                .o_psum_im (w_psum_im[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_res_re    <= w_psum_re[MAX_TAPS];
            r_res_im    <= w_psum_im[MAX_TAPS];
            r_res_final <= w_final;
        end
    end

    assign i_req.ready        = w_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.result_re    = r_res_re;
    assign o_res.result_im    = r_res_im;
    assign o_res.final_result = r_res_final;

`ifndef ASSERT_OFF
    // Only one partial sum may travel the chain at a time.
    a_single_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one partial sum in the tap chain");

    // A request must never disturb the delay line or taps while a sum runs.
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_tok == '0))
        else $error("request accepted while a sum is in flight");

    // A finished sum never overwrites a result that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten before it was taken");

    // The sum handed to the result register arrived from the last cell first.
    a_push_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !$past(w_push)) |-> ($past(w_tok[MAX_TAPS]) || $past(w_push, 1) ||
        !$stable(r_out_valid) || r_out_valid))
        else $error("result pushed without a completed sum");
`endif

endmodule

// ----- tb/linear_convolution_shapes_test.sv -----
// Self-checking bench for the convolution block: directed and random traffic
// across all window shapes, real and complex mode, with idling and back pressure.
// Depends on lcs_pkg, lcs_req_if, lcs_res_if and linear_convolution_shapes.
module linear_convolution_shapes_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS          = lcs_pkg::MAX_TAPS_DEF;
    localparam int SW            = lcs_pkg::SAMPLE_WIDTH_DEF;
    localparam int SETTLE_CYCLES = TAPS + 16;
    localparam int QUIET_LIMIT   = 4000;

    localparam logic [lcs_pkg::SHAPE_W-1:0] SHAPE_SPARE = 2'd3;
    localparam logic signed [SW-1:0]        VAL_MIN     = 16'sh8000;
    localparam logic signed [SW-1:0]        VAL_MAX     = 16'sh7FFF;

    typedef struct packed {
        logic                          operation;
        logic [lcs_pkg::TAP_W-1:0]     tap_index;
        logic signed [SW-1:0]          value_re;
        logic signed [SW-1:0]          value_im;
        logic                          last_sample;
    } t_conv_request;

    typedef struct packed {
        logic signed [lcs_pkg::RES_W-1:0] re;
        logic signed [lcs_pkg::RES_W-1:0] im;
        logic                             final_result;
    } t_conv_output;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lcs_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lcs_req_if req_ch ();
    lcs_res_if res_ch ();

    linear_convolution_shapes i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the block's kernel, delay line and registers.
    logic signed [SW-1:0]          coef_re [TAPS];
    logic signed [SW-1:0]          coef_im [TAPS];
    logic signed [SW-1:0]          line_re [TAPS];
    logic signed [SW-1:0]          line_im [TAPS];
    logic [lcs_pkg::IDX_W-1:0]     vec_position;
    logic [lcs_pkg::KL_W-1:0]      cfg_taps;
    logic [lcs_pkg::SHAPE_W-1:0]   cfg_shape;
    logic                          cfg_complex;

    t_conv_output conv_backlog [$];

    int fault_count;
    int requests_issued;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_shadow();
        coef_re      = '{default: '0};
        coef_im      = '{default: '0};
        line_re      = '{default: '0};
        line_im      = '{default: '0};
        vec_position = '0;
        cfg_taps     = lcs_pkg::KL_W'(1);
        cfg_shape    = lcs_pkg::SHAPE_FULL;
        cfg_complex  = 1'b0;
    endfunction

    function automatic int unsigned taps_active();
        if (cfg_taps == 0) begin
            return 1;
        end
        if (cfg_taps > TAPS) begin
            return TAPS;
        end
        return int'(cfg_taps);
    endfunction

    function automatic void shift_line(input logic signed [SW-1:0] re,
                                       input logic signed [SW-1:0] im);
        for (int i = TAPS - 1; i > 0; i--) begin
            line_re[i] = line_re[i-1];
            line_im[i] = line_im[i-1];
        end
        line_re[0] = re;
        line_im[0] = im;
    endfunction

    function automatic t_conv_output dot_with_kernel();
        longint       acc_re;
        longint       acc_im;
        t_conv_output o;
        acc_re = 0;
        acc_im = 0;
        for (int j = 0; j < taps_active(); j++) begin
            if (cfg_complex) begin
                acc_re += longint'(coef_re[j]) * longint'(line_re[j])
                        - longint'(coef_im[j]) * longint'(line_im[j]);
                acc_im += longint'(coef_re[j]) * longint'(line_im[j])
                        + longint'(coef_im[j]) * longint'(line_re[j]);
            end else begin
                acc_re += longint'(coef_re[j]) * longint'(line_re[j]);
            end
        end
        o.re           = acc_re[lcs_pkg::RES_W-1:0];
        o.im           = acc_im[lcs_pkg::RES_W-1:0];
        o.final_result = 1'b0;
        return o;
    endfunction

    // Applies one accepted request to the shadow state and queues the outputs it causes.
    function automatic void convolve_request(input t_conv_request r);
        int unsigned  taps;
        int unsigned  first_k;
        int unsigned  tail_len;
        int unsigned  k0;
        t_conv_output outs [$];
        if (r.operation == lcs_pkg::OP_LOAD) begin
            coef_re[r.tap_index] = r.value_re;
            coef_im[r.tap_index] = r.value_im;
            return;
        end
        taps = taps_active();
        case (cfg_shape)
            lcs_pkg::SHAPE_FULL: begin
                first_k  = 0;
                tail_len = taps - 1;
            end
            lcs_pkg::SHAPE_SAME: begin
                first_k  = taps / 2;
                tail_len = taps / 2;
            end
            default: begin
                first_k  = taps - 1;
                tail_len = 0;
            end
        endcase
        k0 = 32'(vec_position);
        shift_line(r.value_re, cfg_complex ? r.value_im : {SW{1'b0}});
        if (k0 >= first_k) begin
            outs.push_back(dot_with_kernel());
        end
        if (vec_position != '1) begin
            vec_position++;
        end
        if (r.last_sample) begin
            for (int t = 1; t <= tail_len; t++) begin
                shift_line({SW{1'b0}}, {SW{1'b0}});
                if (k0 + t >= first_k) begin
                    outs.push_back(dot_with_kernel());
                end
            end
            if (outs.size() > 0) begin
                outs[outs.size()-1].final_result = 1'b1;
            end
            line_re      = '{default: '0};
            line_im      = '{default: '0};
            vec_position = '0;
        end
        foreach (outs[i]) begin
            conv_backlog.push_back(outs[i]);
        end
    endfunction

    function automatic logic signed [SW-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [lcs_pkg::KL_W-1:0] pick_kernel_length();
        case ($urandom_range(9))
            0: return '0;
            1: return lcs_pkg::KL_W'(1);
            2: return lcs_pkg::KL_W'(TAPS);
            3: return lcs_pkg::KL_W'($urandom_range(63, TAPS + 1));
            default: return lcs_pkg::KL_W'($urandom_range(8, 2));
        endcase
    endfunction

    task automatic issue_request(input t_conv_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= r.operation;
        req_ch.tap_index   <= r.tap_index;
        req_ch.value_re    <= r.value_re;
        req_ch.value_im    <= r.value_im;
        req_ch.last_sample <= r.last_sample;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        convolve_request(r);
        requests_issued++;
    endtask

    task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im,
                               input logic last);
        t_conv_request r;
        r.operation   = lcs_pkg::OP_SAMPLE;
        r.tap_index   = lcs_pkg::TAP_W'($urandom);
        r.value_re    = re;
        r.value_im    = im;
        r.last_sample = last;
        issue_request(r);
    endtask

    task automatic send_load(input logic [lcs_pkg::TAP_W-1:0] tap,
                             input logic signed [SW-1:0] re,
                             input logic signed [SW-1:0] im, input logic last);
        t_conv_request r;
        r.operation   = lcs_pkg::OP_LOAD;
        r.tap_index   = tap;
        r.value_re    = re;
        r.value_im    = im;
        r.last_sample = last;
        issue_request(r);
    endtask

    // Stops offering requests, waits for every queued output, then lets the
    // block finish any request that produces nothing.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (conv_backlog.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_block(input logic [lcs_pkg::CFG_DATA_W-1:0] taps_word,
                                 input logic [lcs_pkg::CFG_DATA_W-1:0] shape_word,
                                 input logic [lcs_pkg::CFG_DATA_W-1:0] mode_word);
        logic [lcs_pkg::CFG_DATA_W-1:0] words [3];
        logic [lcs_pkg::CFG_IDX_W-1:0]  regs  [3];
        words = '{taps_word, shape_word, mode_word};
        regs  = '{lcs_pkg::REG_KERNEL_LENGTH, lcs_pkg::REG_SHAPE_MODE,
                  lcs_pkg::REG_COMPLEX_MODE};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= words[i];
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b0;
        cfg_taps    = taps_word[lcs_pkg::KL_W-1:0];
        cfg_shape   = shape_word[lcs_pkg::SHAPE_W-1:0];
        cfg_complex = mode_word[0];
    endtask

    task automatic test_defaults_after_reset();
        // The load carries last_sample, which must not close anything.
        send_load(lcs_pkg::TAP_W'(0), VAL_MAX, VAL_MIN, 1'b1);
        send_sample(VAL_MIN, VAL_MAX, 1'b0);
        send_sample(VAL_MAX, '1, 1'b1);
    endtask

    task automatic test_length_and_shape_codes();
        // Length zero acts as one tap, and the spare shape code acts as valid.
        drain_block();
        program_block('0, {4'b1111, SHAPE_SPARE}, 6'b101011);
        send_sample(VAL_MIN, VAL_MIN, 1'b1);
        // Length above the tap count is clamped; the closing sample flushes a full tail.
        drain_block();
        program_block(6'd63, {4'b0000, lcs_pkg::SHAPE_FULL}, 6'b111110);
        send_load(lcs_pkg::TAP_W'(TAPS - 1), VAL_MIN, VAL_MAX, 1'b0);
        send_load(lcs_pkg::TAP_W'(5), VAL_MAX, VAL_MAX, 1'b0);
        send_sample(VAL_MAX, '0, 1'b0);
        send_sample(VAL_MIN, '0, 1'b1);
    endtask

    task automatic test_short_valid_vector();
        drain_block();
        program_block(lcs_pkg::KL_W'(3), {4'b0000, lcs_pkg::SHAPE_VALID}, '0);
        // Stored in real mode, the imaginary part is used later in complex mode.
        send_load(lcs_pkg::TAP_W'(1), 16'sd1234, VAL_MIN, 1'b0);
        send_sample(VAL_MAX, VAL_MAX, 1'b0);
        send_sample(VAL_MIN, VAL_MIN, 1'b1);
        for (int i = 0; i < 4; i++) begin
            send_sample(pick_value(), pick_value(), i == 3);
        end
    endtask

    task automatic test_same_shape_complex();
        drain_block();
        program_block(lcs_pkg::KL_W'(4), {4'b0000, lcs_pkg::SHAPE_SAME}, 6'b000001);
        send_load(lcs_pkg::TAP_W'(2), VAL_MIN, VAL_MIN, 1'b0);
        for (int i = 0; i < 3; i++) begin
            send_sample(VAL_MIN, VAL_MAX, i == 2);
        end
    endtask

    task automatic test_midvector_reconfig();
        drain_block();
        program_block(lcs_pkg::KL_W'(2), {4'b0000, lcs_pkg::SHAPE_FULL}, '0);
        send_sample(VAL_MAX, VAL_MIN, 1'b0);
        drain_block();
        program_block(lcs_pkg::KL_W'(5), {4'b1010, lcs_pkg::SHAPE_SAME}, 6'b000011);
        send_sample(VAL_MIN, VAL_MAX, 1'b0);
        send_sample(VAL_MAX, VAL_MAX, 1'b1);
    endtask

    task automatic test_back_pressure();
        drain_block();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_block(lcs_pkg::KL_W'(8), {4'b0000, lcs_pkg::SHAPE_FULL}, 6'b000001);
        // The sink holds off while the requests keep coming, so the block backs up.
        hold_off_cycles = 400;
        for (int i = 0; i < 14; i++) begin
            send_sample(pick_value(), pick_value(), i == 13);
        end
        drain_block();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int budget);
        int          target;
        int unsigned taps;
        int          n_loads;
        int          n_vec;
        int          len;
        target = requests_issued + budget;
        while (requests_issued < target) begin
            drain_block();
            send_idle_pct  = send_pct;
            recv_stall_pct = recv_pct;
            program_block(pick_kernel_length(), {4'($urandom), 2'($urandom)}, 6'($urandom));
            taps    = taps_active();
            n_loads = (taps < 6) ? int'(taps) : int'($urandom_range(6, 3));
            for (int i = 0; i < n_loads; i++) begin
                if ($urandom_range(4) == 0) begin
                    send_load(lcs_pkg::TAP_W'($urandom), pick_value(), pick_value(),
                              1'($urandom));
                end else if (taps < 6) begin
                    send_load(lcs_pkg::TAP_W'(i), pick_value(), pick_value(), 1'($urandom));
                end else begin
                    send_load(lcs_pkg::TAP_W'($urandom_range(taps - 1)), pick_value(),
                              pick_value(), 1'($urandom));
                end
            end
            n_vec = int'($urandom_range(3, 1));
            for (int v = 0; v < n_vec; v++) begin
                if (requests_issued >= target) begin
                    break;
                end
                len = ($urandom_range(5) == 0) ? int'($urandom_range(40, 11))
                                               : int'($urandom_range(10, 1));
                for (int s = 0; s < len; s++) begin
                    if ($urandom_range(11) == 0) begin
                        send_load(lcs_pkg::TAP_W'($urandom), pick_value(), pick_value(),
                                  1'($urandom));
                    end
                    send_sample(pick_value(), pick_value(), s == len - 1);
                end
            end
        end
    endtask

    // Result side: checks each accepted output and drives the sink's ready.
    initial begin : result_sink
        t_conv_output want;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                if (conv_backlog.size() == 0) begin
                    $error("unexpected output: result_re %0d result_im %0d final_result %0b",
                           res_ch.result_re, res_ch.result_im, res_ch.final_result);
                    fault_count++;
                end else begin
                    want = conv_backlog.pop_front();
                    if (res_ch.result_re !== want.re) begin
                        $error("result_re: expected %0d, actual %0d", want.re, res_ch.result_re);
                        fault_count++;
                    end
                    if (res_ch.result_im !== want.im) begin
                        $error("result_im: expected %0d, actual %0d", want.im, res_ch.result_im);
                        fault_count++;
                    end
                    if (res_ch.final_result !== want.final_result) begin
                        $error("final_result: expected %0b, actual %0b",
                               want.final_result, res_ch.final_result);
                        fault_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run if neither side moves a request or an output for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        fault_count        = 0;
        requests_issued    = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_off_cycles    = 0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = lcs_pkg::REG_KERNEL_LENGTH;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = lcs_pkg::OP_SAMPLE;
        req_ch.tap_index   = '0;
        req_ch.value_re    = '0;
        req_ch.value_im    = '0;
        req_ch.last_sample = 1'b0;
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_after_reset();
        test_length_and_shape_codes();
        test_short_valid_vector();
        test_same_shape_complex();
        test_midvector_reconfig();
        test_back_pressure();
        test_random_traffic(0, 0, 20);
        test_random_traffic(72, 0, 20);
        test_random_traffic(0, 72, 20);
        test_random_traffic(12, 12, 20);

        drain_block();
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
